@@ design/fcdp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the flow class depth policer.
// No dependencies; imported by fcdp_div, flow_class_depth_policer and both bench files.
package fcdp_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ETYPE_W  = 16;
  localparam int PROTO_W  = 8;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int TIME_W   = 64;
  localparam int SLOT_W   = 6;
  localparam int CLASS_W  = 8;
  localparam int DEPTH_W  = 32;

  // Stream widths (payload padded up to whole bytes)
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = 6;

  // Header codes
  localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;

  // Item kinds carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_PACKET   = 2'd0,
    OP_FLOW_WR  = 2'd1,
    OP_LIMIT_WR = 2'd2,
    OP_FLOW_DEL = 2'd3
  } op_e;

  // One flow slot
  typedef struct packed {
    logic                 valid;
    logic [ADDR_W-1:0]    src;
    logic [ADDR_W-1:0]    dst;
    logic [2*PORT_W-1:0]  ports;   // source port in the high half
    logic [PROTO_W-1:0]   proto;
    logic [CLASS_W-1:0]   cls;
  } flow_ent_t;

  // One class bucket
  typedef struct packed {
    logic [DEPTH_W-1:0] limit;
    logic [TIME_W-1:0]  last;
    logic [DEPTH_W-1:0] depth;
  } cls_ent_t;

  // Result beat, verdict in the lowest bit
  typedef struct packed {
    logic [DEPTH_W-1:0] depth_after;
    logic [CLASS_W-1:0] class_used;
    logic               flow_found;
    logic               verdict;
  } res_t;

endpackage

@@ design/fcdp_div.sv @@
`timescale 1ns / 1ps
// Divider of the elapsed time by the constant leak period, by reciprocal multiplication.
// Four 32x32 partial products, low 32 quotient bits kept. Uses fcdp_pkg.
module fcdp_div #(
  parameter int DIVISOR = 10000000
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fcdp_pkg::TIME_W-1:0]  dividend_i,
  output logic                         done_o,
  output logic [fcdp_pkg::DEPTH_W-1:0] quot_o
);
  import fcdp_pkg::*;

  // floor(x / D) == (x * M) >> SHIFT for every 64-bit x, with SHIFT = 64 + ceil(log2 D)
  // and M = floor(2^SHIFT / D) + 1, which always fits in 66 bits
  localparam int LW    = 32;
  localparam int SHIFT = TIME_W + $clog2(DIVISOR);
  localparam int NUM_W = SHIFT + 2;
  localparam int MW    = TIME_W + 2;
  localparam int PW    = TIME_W + MW;
  localparam logic [NUM_W-1:0] RECIP_FULL =
    (NUM_W'(1) << SHIFT) / NUM_W'(DIVISOR) + NUM_W'(1);
  localparam logic [MW-1:0] RECIP     = RECIP_FULL[MW-1:0];
  localparam logic [LW-1:0] RECIP_L0  = RECIP[LW-1:0];
  localparam logic [LW-1:0] RECIP_L1  = RECIP[2*LW-1:LW];
  localparam logic [1:0]    RECIP_TOP = RECIP[MW-1:2*LW];
  localparam logic [2:0]    PARTS     = 3'd4;

  logic                run_q;
  logic                done_q;
  logic                prod_vld_q;
  logic [2:0]          step_q;
  logic [1:0]          prod_pos_q;
  logic [TIME_W-1:0]   dvd_q;
  logic [2*LW-1:0]     prod_q;
  logic [PW-1:0]       acc_q;
  logic [MW-1:0]       top_term;
  logic [LW-1:0]       mul_a, mul_b;
  logic [PW-1:0]       prod_shifted;

  // Top limb of the reciprocal is 0, 1 or 2: shift and add only
  assign top_term = (RECIP_TOP[0] ? {2'b00, dvd_q} : '0) +
                    (RECIP_TOP[1] ? {1'b0, dvd_q, 1'b0} : '0);

  // Partial product operands: step bit 1 picks the dividend limb, bit 0 the reciprocal limb
  assign mul_a = step_q[1] ? dvd_q[2*LW-1:LW] : dvd_q[LW-1:0];
  assign mul_b = step_q[0] ? RECIP_L1 : RECIP_L0;

  // Place the registered partial product at its limb position
  always_comb begin
    case (prod_pos_q)
      2'd0:    prod_shifted = PW'(prod_q);
      2'd1:    prod_shifted = PW'(prod_q) << LW;
      default: prod_shifted = PW'(prod_q) << (2*LW);
    endcase
  end

  // Register each partial product, accumulate it in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= 1'b0;
      done_q     <= 1'b0;
      prod_vld_q <= 1'b0;
      step_q     <= '0;
      prod_pos_q <= '0;
      dvd_q      <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
    end else if (start_i) begin
      run_q      <= 1'b1;
      done_q     <= 1'b0;
      prod_vld_q <= 1'b0;
      step_q     <= '0;
      dvd_q      <= dividend_i;
    end else if (run_q) begin
      if (step_q != PARTS) begin
        prod_q     <= {{LW{1'b0}}, mul_a} * {{LW{1'b0}}, mul_b};
        prod_pos_q <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
        step_q     <= step_q + 3'd1;
      end
      prod_vld_q <= (step_q != PARTS);
      // First run cycle seeds the accumulator with the top-limb term
      if (prod_vld_q) begin
        acc_q <= acc_q + prod_shifted;
      end else begin
        acc_q <= {top_term, {TIME_W{1'b0}}};
      end
      if (prod_vld_q && (prod_pos_q == 2'd2)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[SHIFT +: DEPTH_W];

endmodule

@@ design/flow_class_depth_policer.sv @@
`timescale 1ns / 1ps
// Leaky-bucket policer over flow classes; one item at a time, one result beat per item.
// Flow writes, deletes and unpoliced packets go from accept straight to the result step;
// limit writes pass the bucket write step first. Packets scan the flow table one slot a cycle,
// read the class and, when the bucket leaks, run the reciprocal divide before the judge step;
// the next beat is taken once the result is loaded. Reset: asynchronous, active low; afterwards
// a pass over every slot clears the flow valid bits. Class buckets read as zero until written.
module flow_class_depth_policer #(
  parameter int FLOW_SLOTS  = 64,
  parameter int CLASS_COUNT = 8,
  parameter int DECAY_NS    = 10000000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input beat
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // ether_type[15:0], ip_proto[23:16], headers_complete[24], source_address[56:25],
  // dest_address[88:57], source_port[104:89], dest_port[120:105], time_ns[184:121],
  // slot_index[190:185], class_value[198:191], limit_value[230:199], zero pad[231]
  input  logic [fcdp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [fcdp_pkg::OP_W-1:0]        s_axis_tuser,
  // Result beat
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // verdict[0], flow_found[1], class_used[9:2], depth_after[41:10], zero pad[47:42]
  output logic [fcdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import fcdp_pkg::*;

  localparam int FIDX_W = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CIDX_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam logic [FIDX_W-1:0] FLOW_LAST = FIDX_W'(FLOW_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_CLS, ST_DIV, ST_JUDGE, ST_LIM, ST_DONE
  } state_e;

  // Input field decode
  op_e                 in_op;
  logic [ETYPE_W-1:0]  in_etype;
  logic [PROTO_W-1:0]  in_proto;
  logic                in_complete;
  logic [ADDR_W-1:0]   in_src, in_dst;
  logic [PORT_W-1:0]   in_sport, in_dport;
  logic [TIME_W-1:0]   in_time;
  logic [SLOT_W-1:0]   in_slot;
  logic [CLASS_W-1:0]  in_class;
  logic [DEPTH_W-1:0]  in_limit;

  assign in_op       = op_e'(s_axis_tuser);
  assign in_etype    = s_axis_tdata[15:0];
  assign in_proto    = s_axis_tdata[23:16];
  assign in_complete = s_axis_tdata[24];
  assign in_src      = s_axis_tdata[56:25];
  assign in_dst      = s_axis_tdata[88:57];
  assign in_sport    = s_axis_tdata[104:89];
  assign in_dport    = s_axis_tdata[120:105];
  assign in_time     = s_axis_tdata[184:121];
  assign in_slot     = s_axis_tdata[190:185];
  assign in_class    = s_axis_tdata[198:191];
  assign in_limit    = s_axis_tdata[230:199];

  logic accept, policed, slot_ok, cls_ok;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign policed = (in_etype == ETHERTYPE_IPV4) && in_complete &&
                   ((in_proto == PROTO_TCP) || (in_proto == PROTO_UDP));
  assign slot_ok = 32'(in_slot) < 32'(FLOW_SLOTS);
  assign cls_ok  = 32'(in_class) < 32'(CLASS_COUNT);

  // Control and held item
  state_e              state_q;
  logic [FIDX_W-1:0]   clr_q, cnt_q;
  logic [CIDX_W-1:0]   cls_idx_q;
  logic [ADDR_W-1:0]   key_src_q, key_dst_q;
  logic [2*PORT_W-1:0] key_ports_q;
  logic [PROTO_W-1:0]  key_proto_q;
  logic [TIME_W-1:0]   time_q;
  logic [DEPTH_W-1:0]  new_limit_q;
  logic [DEPTH_W-1:0]  dep_q, lim_q;
  logic [TIME_W-1:0]   last_q;
  res_t                res_q, out_q;
  logic                m_tvalid_q;

  // Flow table memory, single port
  flow_ent_t           flow_mem [FLOW_SLOTS];
  flow_ent_t           flow_rd_q, flow_wdata;
  logic                flow_we, flow_re;
  logic [FIDX_W-1:0]   flow_addr;

  // Class bucket memory, single port, with per-entry valid bits
  cls_ent_t            cls_mem [CLASS_COUNT];
  cls_ent_t            cls_rd_q, cls_wdata, cls_cur;
  logic [CLASS_COUNT-1:0] cls_vld_q;
  logic                cls_rd_vld_q;
  logic                cls_we, cls_re;
  logic [CIDX_W-1:0]   cls_addr;

  // Divider
  logic                div_start, div_done;
  logic [TIME_W-1:0]   div_dvd;
  logic [DEPTH_W-1:0]  div_quot;

  logic hit, scan_last, hit_cls_ok, drop;

  assign cls_cur    = cls_rd_vld_q ? cls_rd_q : '0;
  assign hit        = flow_rd_q.valid && (flow_rd_q.src == key_src_q) &&
                      (flow_rd_q.dst == key_dst_q) && (flow_rd_q.ports == key_ports_q) &&
                      (flow_rd_q.proto == key_proto_q);
  assign scan_last  = (cnt_q == FLOW_LAST);
  assign hit_cls_ok = 32'(flow_rd_q.cls) < 32'(CLASS_COUNT);
  assign drop       = (dep_q >= lim_q);

  // Memory port control
  always_comb begin
    flow_we    = 1'b0;
    flow_re    = 1'b0;
    flow_addr  = cnt_q;
    flow_wdata = '0;
    cls_we     = 1'b0;
    cls_re     = 1'b0;
    cls_addr   = cls_idx_q;
    cls_wdata  = '0;
    div_start  = 1'b0;
    div_dvd    = time_q - cls_cur.last;
    unique case (state_q)
      ST_CLEAR: begin
        flow_we   = 1'b1;
        flow_addr = clr_q;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_PACKET: begin
              flow_re   = policed;
              flow_addr = '0;
            end
            OP_FLOW_WR: begin
              flow_we    = slot_ok;
              flow_addr  = FIDX_W'(in_slot);
              flow_wdata = '{valid: 1'b1, src: in_src, dst: in_dst,
                             ports: {in_sport, in_dport}, proto: in_proto, cls: in_class};
            end
            OP_FLOW_DEL: begin
              flow_we   = slot_ok;
              flow_addr = FIDX_W'(in_slot);
            end
            OP_LIMIT_WR: begin
              cls_re   = cls_ok;
              cls_addr = CIDX_W'(in_class);
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          cls_re   = hit_cls_ok;
          cls_addr = CIDX_W'(flow_rd_q.cls);
        end else if (!scan_last) begin
          flow_re   = 1'b1;
          flow_addr = cnt_q + FIDX_W'(1);
        end
      end
      ST_CLS: begin
        div_start = (cls_cur.depth != '0) && (cls_cur.last != '0);
      end
      ST_JUDGE: begin
        cls_we    = 1'b1;
        cls_wdata = drop ? cls_ent_t'{limit: lim_q, last: last_q, depth: dep_q}
                         : cls_ent_t'{limit: lim_q, last: time_q,
                                      depth: dep_q + DEPTH_W'(1)};
      end
      ST_LIM: begin
        cls_we    = 1'b1;
        cls_wdata = '{limit: new_limit_q, last: cls_cur.last, depth: cls_cur.depth};
      end
      default: ;
    endcase
  end

  // Flow table access
  always_ff @(posedge clk_i) begin
    if (flow_we) begin
      flow_mem[flow_addr] <= flow_wdata;
    end
    if (flow_re) begin
      flow_rd_q <= flow_mem[flow_addr];
    end
  end

  // Class bucket access
  always_ff @(posedge clk_i) begin
    if (cls_we) begin
      cls_mem[cls_addr] <= cls_wdata;
    end
    if (cls_re) begin
      cls_rd_q <= cls_mem[cls_addr];
    end
  end

  fcdp_div #(
    .DIVISOR(DECAY_NS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Sequencer, held item and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      cnt_q        <= '0;
      cls_idx_q    <= '0;
      cls_vld_q    <= '0;
      cls_rd_vld_q <= 1'b0;
      key_src_q    <= '0;
      key_dst_q    <= '0;
      key_ports_q  <= '0;
      key_proto_q  <= '0;
      time_q       <= '0;
      new_limit_q  <= '0;
      dep_q        <= '0;
      lim_q        <= '0;
      last_q       <= '0;
      res_q        <= '0;
      out_q        <= '0;
      m_tvalid_q   <= 1'b0;
    end else begin
      // Taken beat drops valid unless a new one is loaded below
      if (m_tvalid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      if (cls_we) begin
        cls_vld_q[cls_addr] <= 1'b1;
      end
      if (cls_re) begin
        cls_rd_vld_q <= cls_vld_q[cls_addr];
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + FIDX_W'(1);
          if (clr_q == FLOW_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_q       <= '0;
            key_src_q   <= in_src;
            key_dst_q   <= in_dst;
            key_ports_q <= {in_sport, in_dport};
            key_proto_q <= in_proto;
            time_q      <= in_time;
            new_limit_q <= in_limit;
            cls_idx_q   <= CIDX_W'(in_class);
            cnt_q       <= '0;
            unique case (in_op)
              OP_PACKET:   state_q <= policed ? ST_SCAN : ST_DONE;
              OP_LIMIT_WR: state_q <= cls_ok ? ST_LIM : ST_DONE;
              default:     state_q <= ST_DONE;
            endcase
          end
        end
        ST_SCAN: begin
          // First matching slot wins
          if (hit) begin
            res_q.flow_found <= 1'b1;
            res_q.class_used <= flow_rd_q.cls;
            cls_idx_q        <= CIDX_W'(flow_rd_q.cls);
            state_q          <= hit_cls_ok ? ST_CLS : ST_DONE;
          end else if (scan_last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + FIDX_W'(1);
          end
        end
        ST_CLS: begin
          dep_q   <= cls_cur.depth;
          lim_q   <= cls_cur.limit;
          last_q  <= cls_cur.last;
          state_q <= div_start ? ST_DIV : ST_JUDGE;
        end
        ST_DIV: begin
          // Leak with a floor at zero
          if (div_done) begin
            dep_q   <= (div_quot >= dep_q) ? '0 : dep_q - div_quot;
            state_q <= ST_JUDGE;
          end
        end
        ST_JUDGE: begin
          res_q.verdict     <= drop;
          res_q.depth_after <= drop ? dep_q : dep_q + DEPTH_W'(1);
          state_q           <= ST_DONE;
        end
        ST_LIM: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid_q || m_axis_tready) begin
            out_q      <= res_q;
            m_tvalid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q};

  // Checks
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (32'(cnt_q) < 32'(FLOW_SLOTS)))
    else $error("flow scan index beyond table");

  a_div_only_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside of leak step");

  a_cls_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_we |-> (32'(cls_addr) < 32'(CLASS_COUNT)))
    else $error("class write out of range");

  a_drop_has_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!out_q.verdict || out_q.flow_found))
    else $error("drop without matched flow");

endmodule

@@ tb/sv/fcdp_verdict_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for flow_class_depth_policer: watches both stream channels, predicts each result beat.
// Depends on fcdp_pkg for the op codes, header codes and the result beat layout.
module fcdp_verdict_checker #(
  parameter int FLOW_SLOTS  = 64,
  parameter int CLASS_COUNT = 8,
  parameter int DECAY_NS    = 10000000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [fcdp_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [fcdp_pkg::OP_W-1:0]        s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [fcdp_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int                               mismatches_o,
  output int                               awaiting_o
);
  import fcdp_pkg::*;

  // Input beat as laid out on tdata, highest field first
  typedef struct packed {
    logic                pad;
    logic [DEPTH_W-1:0]  limit_value;
    logic [CLASS_W-1:0]  class_value;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   time_ns;
    logic [PORT_W-1:0]   dport;
    logic [PORT_W-1:0]   sport;
    logic [ADDR_W-1:0]   daddr;
    logic [ADDR_W-1:0]   saddr;
    logic                hdr_ok;
    logic [PROTO_W-1:0]  proto;
    logic [ETYPE_W-1:0]  etype;
  } item_t;

  localparam int RES_W = $bits(res_t);

  // Shadow of the flow table and the class buckets
  logic [ADDR_W-1:0]   slot_src   [FLOW_SLOTS];
  logic [ADDR_W-1:0]   slot_dst   [FLOW_SLOTS];
  logic [2*PORT_W-1:0] slot_ports [FLOW_SLOTS];
  logic [PROTO_W-1:0]  slot_proto [FLOW_SLOTS];
  logic [CLASS_W-1:0]  slot_cls   [FLOW_SLOTS];
  logic                slot_live  [FLOW_SLOTS];
  logic [DEPTH_W-1:0]  bucket_depth [CLASS_COUNT];
  logic [TIME_W-1:0]   bucket_stamp [CLASS_COUNT];
  logic [DEPTH_W-1:0]  bucket_limit [CLASS_COUNT];

  res_t verdict_q[$];

  initial begin
    mismatches_o = 0;
    awaiting_o   = 0;
    for (int i = 0; i < FLOW_SLOTS; i++) begin
      slot_live[i] = 1'b0;
    end
    for (int i = 0; i < CLASS_COUNT; i++) begin
      bucket_depth[i] = '0;
      bucket_stamp[i] = '0;
      bucket_limit[i] = '0;
    end
  end

  // Apply one command to the shadow state and return the result it should produce
  function automatic res_t police_beat(input op_e op, input item_t b);
    res_t               r;
    logic [2*PORT_W-1:0] ports;
    logic [TIME_W-1:0]  elapsed;
    logic [DEPTH_W-1:0] leak;
    logic [CLASS_W-1:0] c;
    int                 hit;
    r     = '0;
    ports = {b.sport, b.dport};
    hit   = -1;
    case (op)
      OP_FLOW_WR: begin
        if (b.slot < FLOW_SLOTS) begin
          slot_src[b.slot]   = b.saddr;
          slot_dst[b.slot]   = b.daddr;
          slot_ports[b.slot] = ports;
          slot_proto[b.slot] = b.proto;
          slot_cls[b.slot]   = b.class_value;
          slot_live[b.slot]  = 1'b1;
        end
      end
      OP_LIMIT_WR: begin
        if (b.class_value < CLASS_COUNT) bucket_limit[b.class_value] = b.limit_value;
      end
      OP_FLOW_DEL: begin
        if (b.slot < FLOW_SLOTS) slot_live[b.slot] = 1'b0;
      end
      OP_PACKET: begin
        if (b.etype == ETHERTYPE_IPV4 && b.hdr_ok &&
            (b.proto == PROTO_TCP || b.proto == PROTO_UDP)) begin
          // lowest matching live slot wins
          for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (hit < 0 && slot_live[i] && slot_src[i] == b.saddr && slot_dst[i] == b.daddr &&
                slot_ports[i] == ports && slot_proto[i] == b.proto) hit = i;
          end
          if (hit >= 0) begin
            c            = slot_cls[hit];
            r.flow_found = 1'b1;
            r.class_used = c;
            if (c < CLASS_COUNT) begin
              // leak only when the bucket holds something and has a nonzero stamp
              if (bucket_depth[c] != '0 && bucket_stamp[c] != '0) begin
                elapsed = b.time_ns - bucket_stamp[c];
                leak    = DEPTH_W'(elapsed / TIME_W'(DECAY_NS));
                bucket_depth[c] = (leak >= bucket_depth[c]) ? '0 : bucket_depth[c] - leak;
              end
              if (bucket_depth[c] >= bucket_limit[c]) begin
                r.verdict = 1'b1;
              end else begin
                bucket_depth[c] = bucket_depth[c] + 1'b1;
                bucket_stamp[c] = b.time_ns;
              end
              r.depth_after = bucket_depth[c];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic note_miss(input string what, input logic [63:0] want, input logic [63:0] got);
    if (mismatches_o < 10)
      $display("%0t fcdp mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    mismatches_o++;
  endtask

  // Predict on every accepted input beat, compare on every accepted result beat
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        verdict_q.push_back(police_beat(op_e'(s_tuser_i), item_t'(s_tdata_i)));
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[RES_W-1:0]);
        if (verdict_q.size() == 0) begin
          note_miss("result beat with nothing pending", '0, 64'(m_tdata_i));
        end else begin
          want = verdict_q.pop_front();
          if (got.verdict !== want.verdict)
            note_miss("verdict", 64'(want.verdict), 64'(got.verdict));
          if (got.flow_found !== want.flow_found)
            note_miss("flow_found", 64'(want.flow_found), 64'(got.flow_found));
          if (got.class_used !== want.class_used)
            note_miss("class_used", 64'(want.class_used), 64'(got.class_used));
          if (got.depth_after !== want.depth_after)
            note_miss("depth_after", 64'(want.depth_after), 64'(got.depth_after));
          if (m_tdata_i[OUT_TDATA_W-1:RES_W] !== '0)
            note_miss("tdata pad", '0, 64'(m_tdata_i[OUT_TDATA_W-1:RES_W]));
        end
      end
      awaiting_o <= verdict_q.size();
    end
  end

endmodule

@@ tb/sv/tb_flow_class_depth_policer.sv @@
`timescale 1ns / 1ps
// Top of the policer bench: clock, reset, command stimulus, result-side backpressure, verdict.
// Depends on fcdp_pkg, flow_class_depth_policer and fcdp_verdict_checker.
module tb_flow_class_depth_policer;
  import fcdp_pkg::*;

  localparam int     FLOW_SLOTS   = 64;
  localparam int     CLASSES      = 8;
  localparam int     DECAY        = 10000000;
  localparam int     CLK_PERIOD   = 20;
  localparam int     RANDOM_ITEMS = 1650;
  localparam int     POOL         = 16;
  localparam int     HOLD_CYCLES  = 3000;
  localparam int     END_SETTLE   = 250;
  localparam longint RUN_LIMIT_NS = 64'd30_000_000;

  // Five-tuple of a flow
  typedef struct packed {
    logic [ADDR_W-1:0]  sa;
    logic [ADDR_W-1:0]  da;
    logic [PORT_W-1:0]  sp;
    logic [PORT_W-1:0]  dp;
    logic [PROTO_W-1:0] pr;
  } tuple_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // ether_type, ip_proto, headers_complete, source_address, dest_address, source_port,
  // dest_port, time_ns, slot_index, class_value, limit_value, zero pad (lowest bit up)
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // opcode
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // verdict, flow_found, class_used, depth_after, zero pad (lowest bit up)
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int     mismatches;
  int     awaiting;
  logic   gaps_on = 1'b1;
  logic   hold_rx = 1'b0;
  logic   hold_done = 1'b0;
  tuple_t flow_pool [POOL];

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  flow_class_depth_policer #(
    .FLOW_SLOTS (FLOW_SLOTS),
    .CLASS_COUNT(CLASSES),
    .DECAY_NS   (DECAY)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  fcdp_verdict_checker #(
    .FLOW_SLOTS (FLOW_SLOTS),
    .CLASS_COUNT(CLASSES),
    .DECAY_NS   (DECAY)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .mismatches_o(mismatches),
    .awaiting_o  (awaiting)
  );

  // Random tuple; policed ones carry TCP or UDP, otherwise any protocol
  function automatic tuple_t rand_tuple(input logic policed);
    tuple_t f;
    f.sa = $urandom;
    f.da = $urandom;
    f.sp = PORT_W'($urandom);
    f.dp = PORT_W'($urandom);
    if (policed) f.pr = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
    else f.pr = PROTO_W'($urandom);
    return f;
  endfunction

  // Offer one beat, with random idle cycles first, and hold it until taken
  task automatic offer_beat(input op_e op, input logic [ETYPE_W-1:0] etype, input logic hdr,
                            input tuple_t f, input logic [TIME_W-1:0] t,
                            input logic [SLOT_W-1:0] slot, input logic [CLASS_W-1:0] cls,
                            input logic [DEPTH_W-1:0] lim);
    logic took;
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, lim, cls, slot, t, f.dp, f.sp, f.da, f.sa, hdr, f.pr, etype};
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Command wrappers; fields a command ignores carry random junk
  task automatic send_packet(input tuple_t f, input logic [ETYPE_W-1:0] etype, input logic hdr,
                             input logic [TIME_W-1:0] t);
    offer_beat(OP_PACKET, etype, hdr, f, t, SLOT_W'($urandom), CLASS_W'($urandom), $urandom);
  endtask

  task automatic send_flow(input logic [SLOT_W-1:0] slot, input tuple_t f,
                           input logic [CLASS_W-1:0] cls);
    offer_beat(OP_FLOW_WR, ETYPE_W'($urandom), 1'($urandom), f, {$urandom, $urandom}, slot, cls,
               $urandom);
  endtask

  task automatic send_limit(input logic [CLASS_W-1:0] cls, input logic [DEPTH_W-1:0] lim);
    offer_beat(OP_LIMIT_WR, ETYPE_W'($urandom), 1'($urandom), rand_tuple(1'b0),
               {$urandom, $urandom}, SLOT_W'($urandom), cls, lim);
  endtask

  task automatic send_delete(input logic [SLOT_W-1:0] slot);
    offer_beat(OP_FLOW_DEL, ETYPE_W'($urandom), 1'($urandom), rand_tuple(1'b0),
               {$urandom, $urandom}, slot, CLASS_W'($urandom), $urandom);
  endtask

  // Result side: random stalls, one long hold-off, and a stretch with none
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rx && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 37);
      end
    end
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    tuple_t             a, b, c, e, z, f;
    logic [TIME_W-1:0]  clock_ns;
    logic [ETYPE_W-1:0] etype;
    logic [CLASS_W-1:0] cls;
    logic [DEPTH_W-1:0] lim;
    logic               hdr;
    int                 roll;
    int                 pick;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PACKET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    a    = rand_tuple(1'b1);
    a.pr = PROTO_TCP;
    b    = rand_tuple(1'b1);
    b.pr = PROTO_UDP;
    c    = rand_tuple(1'b1);
    e    = '{sa: '1, da: '0, sp: '1, dp: '0, pr: PROTO_TCP};
    z    = '{sa: '0, da: '0, sp: '0, dp: '0, pr: PROTO_UDP};

    // Directed: empty table, limits incl. out-of-range class, duplicates, zero time,
    // time wrap, huge elapsed, class out of range, unpoliced headers, deletes
    send_packet(a, ETHERTYPE_IPV4, 1'b1, '0);
    send_limit(0, 2);
    send_limit(7, '1);
    send_limit(8'd200, 5);
    send_limit(3, 0);
    send_flow(0, a, 0);
    send_flow(63, b, 7);
    send_flow(5, a, 3);
    send_flow(10, c, '1);
    send_flow(20, e, 1);
    send_flow(21, z, 2);
    send_packet(a, ETHERTYPE_IPV4, 1'b1, '0);
    send_packet(a, ETHERTYPE_IPV4, 1'b1, 5);
    send_packet(a, ETHERTYPE_IPV4, 1'b1, 6);
    send_packet(a, ETHERTYPE_IPV4, 1'b1, 64'd30_000_005);
    send_packet(b, ETHERTYPE_IPV4, 1'b1, '1);
    send_packet(b, ETHERTYPE_IPV4, 1'b1, 1);
    send_packet(c, ETHERTYPE_IPV4, 1'b1, 7);
    send_packet(e, ETHERTYPE_IPV4, 1'b1, 64'h4000_0000_0000_0000);
    send_packet(z, 16'hFFFF, 1'b1, 9);
    send_packet(a, 16'h0000, 1'b1, 11);
    f    = a;
    f.pr = 8'd1;
    send_packet(f, ETHERTYPE_IPV4, 1'b1, 12);
    send_packet(a, ETHERTYPE_IPV4, 1'b0, 13);
    send_delete(0);
    send_delete(40);
    send_packet(a, ETHERTYPE_IPV4, 1'b1, 64'h8000_0000_0000_0000);
    send_packet(b, ETHERTYPE_IPV4, 1'b1, 64'h8000_0000_0000_0000);

    // Random: mostly packets of known flows with a stepping clock, plus table churn and noise
    for (int i = 0; i < POOL; i++) flow_pool[i] = rand_tuple(1'b1);
    flow_pool[0] = a;
    flow_pool[1] = b;
    clock_ns     = 64'd1000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 900 && n < 1150);
      if (n == 500) hold_rx = 1'b1;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, POOL - 1);
      if (roll < 12) begin
        if ($urandom_range(0, 4) == 0) flow_pool[pick] = rand_tuple(1'b1);
        f = flow_pool[pick];
        if ($urandom_range(0, 19) == 0) f.pr = PROTO_W'($urandom);
        cls = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom) :
                                            CLASS_W'($urandom_range(0, CLASSES - 1));
        send_flow(SLOT_W'($urandom), f, cls);
      end else if (roll < 17) begin
        cls = ($urandom_range(0, 7) == 0) ? CLASS_W'($urandom) :
                                            CLASS_W'($urandom_range(0, CLASSES - 1));
        case ($urandom_range(0, 19))
          0:       lim = '1;
          1, 2:    lim = $urandom;
          3, 4, 5: lim = $urandom_range(7, 40);
          default: lim = $urandom_range(0, 6);
        endcase
        send_limit(cls, lim);
      end else if (roll < 21) begin
        send_delete(SLOT_W'($urandom));
      end else begin
        // clock mostly advances a few leak periods at a time
        case ($urandom_range(0, 49))
          0:             clock_ns = {$urandom, $urandom};
          1:             clock_ns = '0;
          2, 3, 4, 5, 6: clock_ns = clock_ns + $urandom_range(0, 1000);
          default:       clock_ns = clock_ns + $urandom_range(0, 25_000_000);
        endcase
        f     = flow_pool[pick];
        etype = ETHERTYPE_IPV4;
        hdr   = 1'b1;
        case ($urandom_range(0, 19))
          0:       etype = ETYPE_W'($urandom);
          1:       f.pr = PROTO_W'($urandom);
          2:       hdr = 1'b0;
          3:       f = rand_tuple(1'b1);
          default: ;
        endcase
        send_packet(f, etype, hdr, clock_ns);
      end
    end
    s_axis_tvalid <= 1'b0;
    gaps_on = 1'b1;

    // Drain, then give the block time to show any stray beat
    do @(negedge clk_i); while (awaiting != 0);
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
